[rtl/carf_pkg.sv]
`timescale 1ns / 1ps

package carf_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int CLIP_DEPTH = 8;

   localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int XW        = $clog2(MAX_WIDTH + 1);
   localparam int YW        = $clog2(MAX_HEIGHT + 1);
   localparam int CNT_W     = $clog2(CLIP_DEPTH + 1);
   localparam int CIDX_W    = (CLIP_DEPTH > 1) ? $clog2(CLIP_DEPTH) : 1;
   localparam int CRD_W     = 20;
   localparam int CSR_W     = 9;

   localparam logic [2:0] CMD_CLEAR = 3'd0;
   localparam logic [2:0] CMD_FILL  = 3'd1;
   localparam logic [2:0] CMD_PUSH  = 3'd2;
   localparam logic [2:0] CMD_POP   = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   localparam logic [1:0] STS_DONE    = 2'd0;
   localparam logic [1:0] STS_FULL    = 2'd1;
   localparam logic [1:0] STS_OUTSIDE = 2'd2;

   localparam logic [0:0] CSR_CANVAS_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_CANVAS_HEIGHT = 1'b1;

   localparam logic [2:0] STRIP_LAST = 3'd4;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic latch;
      logic clr_start;
      logic clr_step;
      logic strip_clr;
      logic strip_inc;
      logic box_load;
      logic clip_step;
      logic edge_load;
      logic pix_read;
      logic pix_mul;
      logic pix_write;
      logic push;
      logic pop;
      logic read_issue;
   } carf_cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic [2:0] command;
      logic       clr_last;
      logic       clip_done;
      logic       box_empty;
      logic       pix_last;
      logic       strip_last;
   } carf_sts_type;

endpackage

[rtl/carf_ctrl.sv]
`timescale 1ns / 1ps

module carf_ctrl
   import carf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_valid,
   output carf_cmd_type cmd,
   input  carf_sts_type sts
);

   localparam logic [3:0] S_INIT = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_DISP = 4'd2;
   localparam logic [3:0] S_CLR  = 4'd3;
   localparam logic [3:0] S_BOX  = 4'd4;
   localparam logic [3:0] S_CLIP = 4'd5;
   localparam logic [3:0] S_EDGE = 4'd6;
   localparam logic [3:0] S_RD   = 4'd7;
   localparam logic [3:0] S_MUL  = 4'd8;
   localparam logic [3:0] S_WR   = 4'd9;
   localparam logic [3:0] S_NEXT = 4'd10;
   localparam logic [3:0] S_RESP = 4'd11;

   logic [3:0] state_ff, state_in;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_DISP;
            end
         end
         S_DISP: begin
            unique case (sts.command)
               CMD_CLEAR: begin
                  cmd.clr_start = 1'b1;
                  state_in      = S_CLR;
               end
               CMD_FILL: begin
                  cmd.strip_clr = 1'b1;
                  state_in      = S_BOX;
               end
               CMD_PUSH: begin
                  cmd.push = 1'b1;
                  state_in = S_RESP;
               end
               CMD_POP: begin
                  cmd.pop  = 1'b1;
                  state_in = S_RESP;
               end
               CMD_READ: begin
                  cmd.read_issue = 1'b1;
                  state_in       = S_RESP;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = S_RESP;
         end
         S_BOX: begin
            cmd.box_load = 1'b1;
            state_in     = S_CLIP;
         end
         S_CLIP: begin
            if (sts.clip_done) state_in = S_EDGE;
            else cmd.clip_step = 1'b1;
         end
         S_EDGE: begin
            if (sts.box_empty) state_in = S_NEXT;
            else begin
               cmd.edge_load = 1'b1;
               state_in      = S_RD;
            end
         end
         S_RD: begin
            cmd.pix_read = 1'b1;
            state_in     = S_MUL;
         end
         S_MUL: begin
            cmd.pix_mul = 1'b1;
            state_in    = S_WR;
         end
         S_WR: begin
            cmd.pix_write = 1'b1;
            state_in      = sts.pix_last ? S_NEXT : S_RD;
         end
         S_NEXT: begin
            if (sts.strip_last) state_in = S_RESP;
            else begin
               cmd.strip_inc = 1'b1;
               state_in      = S_BOX;
            end
         end
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_INIT;
      else state_ff <= state_in;
   end

endmodule

[rtl/carf_dp.sv]
`timescale 1ns / 1ps

module carf_dp
   import carf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  carf_cmd_type       cmd,
   output carf_sts_type       sts,
   input  logic [XW-1:0]      eff_w,
   input  logic [YW-1:0]      eff_h,
   input  logic [2:0]         req_command,
   input  logic signed [15:0] req_rect_x,
   input  logic signed [15:0] req_rect_y,
   input  logic signed [15:0] req_rect_width,
   input  logic signed [15:0] req_rect_height,
   input  logic [31:0]        req_fill_color,
   input  logic [31:0]        req_border_color,
   input  logic [14:0]        req_border_width,
   output logic [31:0]        rsp_pixel_rgba,
   output logic [1:0]         rsp_status
);

   typedef logic signed [CRD_W-1:0] crd_type;

   // Latched request.
   logic [2:0]  command_ff;
   logic signed [15:0] rx_ff, ry_ff, rw_ff, rh_ff;
   logic [31:0] fc_ff, bc_ff;
   logic [14:0] bw_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         command_ff <= req_command;
         rx_ff      <= req_rect_x;
         ry_ff      <= req_rect_y;
         rw_ff      <= req_rect_width;
         rh_ff      <= req_rect_height;
         fc_ff      <= req_fill_color;
         bc_ff      <= req_border_color;
         bw_ff      <= req_border_width;
      end
   end

   // Clip stack.
   logic signed [15:0] clip_x_ff [CLIP_DEPTH];
   logic signed [15:0] clip_y_ff [CLIP_DEPTH];
   logic signed [15:0] clip_w_ff [CLIP_DEPTH];
   logic signed [15:0] clip_h_ff [CLIP_DEPTH];
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   cidx_ff;
   logic               full;

   assign full = (count_ff >= CNT_W'(CLIP_DEPTH));

   always_ff @(posedge clock) begin
      if (cmd.push && !full) begin
         clip_x_ff[count_ff[CIDX_W-1:0]] <= rx_ff;
         clip_y_ff[count_ff[CIDX_W-1:0]] <= ry_ff;
         clip_w_ff[count_ff[CIDX_W-1:0]] <= rw_ff;
         clip_h_ff[count_ff[CIDX_W-1:0]] <= rh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clr_start) count_ff <= '0;
      else if (cmd.push && !full) count_ff <= count_ff + 1'b1;
      else if (cmd.pop && count_ff != '0) count_ff <= count_ff - 1'b1;
   end

   // Working box as left, top, right, bottom edges in 12.4.
   crd_type l_ff, t_ff, r_ff, b_ff;
   logic    skip_ff;
   logic [2:0]  strip_ff;
   logic [31:0] color_ff;
   crd_type rx, ry, rw, rh, bw, cw16, ch16;
   crd_type sl, st, sr, sb;

   assign rx   = CRD_W'(rx_ff);
   assign ry   = CRD_W'(ry_ff);
   assign rw   = CRD_W'(rw_ff);
   assign rh   = CRD_W'(rh_ff);
   assign bw   = crd_type'({{(CRD_W - 15){1'b0}}, bw_ff});
   assign cw16 = crd_type'({{(CRD_W - XW - 4){1'b0}}, eff_w, 4'b0000});
   assign ch16 = crd_type'({{(CRD_W - YW - 4){1'b0}}, eff_h, 4'b0000});

   always_comb begin
      sl = rx;
      st = ry;
      sr = rx + rw;
      sb = ry + rh;
      case (strip_ff)
         3'd1: sb = ry + bw;
         3'd2: st = ry + rh - bw;
         3'd3: begin
            st = ry + bw;
            sr = rx + bw;
            sb = ry + rh - bw;
         end
         3'd4: begin
            sl = rx + rw - bw;
            st = ry + bw;
            sb = ry + rh - bw;
         end
         default: ;
      endcase
   end

   crd_type cl, ct, cr, cb;
   assign cl = CRD_W'(clip_x_ff[cidx_ff[CIDX_W-1:0]]);
   assign ct = CRD_W'(clip_y_ff[cidx_ff[CIDX_W-1:0]]);
   assign cr = cl + CRD_W'(clip_w_ff[cidx_ff[CIDX_W-1:0]]);
   assign cb = ct + CRD_W'(clip_h_ff[cidx_ff[CIDX_W-1:0]]);

   always_ff @(posedge clock) begin
      if (cmd.strip_clr) strip_ff <= '0;
      else if (cmd.strip_inc) strip_ff <= strip_ff + 3'd1;
      if (cmd.box_load) begin
         l_ff     <= (sl > 0) ? sl : '0;
         t_ff     <= (st > 0) ? st : '0;
         r_ff     <= (sr < cw16) ? sr : cw16;
         b_ff     <= (sb < ch16) ? sb : ch16;
         skip_ff  <= (strip_ff != '0) && (bw_ff == '0 || bc_ff[7:0] == 8'd0);
         color_ff <= (strip_ff == '0) ? fc_ff : bc_ff;
         cidx_ff  <= '0;
      end else if (cmd.clip_step) begin
         if (cl > l_ff) l_ff <= cl;
         if (ct > t_ff) t_ff <= ct;
         if (cr < r_ff) r_ff <= cr;
         if (cb < b_ff) b_ff <= cb;
         cidx_ff <= cidx_ff + 1'b1;
      end
   end

   // Pixel walk. Once non-empty the box lies inside the canvas, so rounding
   // the edges already stays within 0..width.
   logic [XW-1:0] x_ff, x0_ff, x1_ff;
   logic [YW-1:0] y_ff, y1_ff;
   crd_type       rc, bc;
   logic          x_end;

   assign rc    = r_ff + crd_type'(15);
   assign bc    = b_ff + crd_type'(15);
   assign x_end = (x_ff + 1'b1 == x1_ff);

   always_ff @(posedge clock) begin
      if (cmd.edge_load) begin
         x0_ff <= l_ff[XW+3:4];
         x_ff  <= l_ff[XW+3:4];
         y_ff  <= t_ff[YW+3:4];
         x1_ff <= rc[XW+3:4];
         y1_ff <= bc[YW+3:4];
      end else if (cmd.pix_write) begin
         if (x_end) begin
            x_ff <= x0_ff;
            y_ff <= y_ff + 1'b1;
         end else x_ff <= x_ff + 1'b1;
      end
   end

   // Pixel read coordinates.
   logic signed [11:0] col, row;
   logic               outside;
   assign col     = rx_ff[15:4];
   assign row     = ry_ff[15:4];
   assign outside = col < 0 || row < 0
                 || 13'(col) >= 13'(eff_w) || 13'(row) >= 13'(eff_h);

   // Frame store.
   logic [31:0]       mem_ff [MEM_DEPTH];
   logic [31:0]       rdata_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] pix_addr, rd_addr;
   logic              clr_last;

   assign pix_addr = ADDR_W'(y_ff * MAX_WIDTH + x_ff);
   assign rd_addr  = cmd.read_issue
                   ? ADDR_W'(row[YW-1:0] * MAX_WIDTH + col[XW-1:0]) : pix_addr;
   assign clr_last = (clr_addr_ff == ADDR_W'(MEM_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset || cmd.clr_start) clr_addr_ff <= '0;
      else if (cmd.clr_step) clr_addr_ff <= clr_addr_ff + 1'b1;
   end

   // Blend: per channel s*a + d*(255-a), then divide by 255.
   logic [15:0] prod_ff [4];
   logic [7:0]  alpha, inv;
   logic [7:0]  src [4];
   logic [7:0]  quo [4];
   logic [16:0] qsum [4];

   assign alpha  = color_ff[7:0];
   assign inv    = 8'd255 - alpha;
   assign src[0] = color_ff[31:24];
   assign src[1] = color_ff[23:16];
   assign src[2] = color_ff[15:8];
   assign src[3] = 8'd255;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         qsum[i] = 17'(prod_ff[i]) + 17'(prod_ff[i][15:8]) + 17'd1;
         quo[i]  = qsum[i][15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pix_mul) begin
         for (int i = 0; i < 4; i++) begin
            prod_ff[i] <= 16'(src[i]) * 16'(alpha)
                        + 16'(rdata_ff[31 - 8 * i -: 8]) * 16'(inv);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_step) mem_ff[clr_addr_ff] <= '0;
      else if (cmd.pix_write) mem_ff[pix_addr] <= {quo[0], quo[1], quo[2], quo[3]};
      if (cmd.pix_read || cmd.read_issue) rdata_ff <= mem_ff[rd_addr];
   end

   // Status of the request.
   logic [1:0] status_ff;
   logic       is_read_ff;
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         status_ff  <= STS_DONE;
         is_read_ff <= 1'b0;
      end else if (cmd.push && full) status_ff <= STS_FULL;
      else if (cmd.read_issue) begin
         status_ff  <= outside ? STS_OUTSIDE : STS_DONE;
         is_read_ff <= !outside;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_pixel_rgba = is_read_ff ? rdata_ff : '0;

   assign sts.command    = command_ff;
   assign sts.clr_last   = clr_last;
   assign sts.clip_done  = (cidx_ff >= count_ff);
   assign sts.box_empty  = skip_ff || (r_ff <= l_ff) || (b_ff <= t_ff);
   assign sts.pix_last   = x_end && (y_ff + 1'b1 == y1_ff);
   assign sts.strip_last = (strip_ff == STRIP_LAST);

endmodule

[rtl/clipped_alpha_rect_fill.sv]
`timescale 1ns / 1ps

// Rectangle fill engine over a 256 x 256 RGBA8 frame store with a clip stack
// of eight entries. Raise start with a request on the req_ ports while busy is
// low; exactly one response follows, shown on the rsp_ ports for a single
// cycle with rsp_valid high. The receiver cannot stall a response, so it must
// capture it in that cycle. After reset the engine sweeps the frame store to
// zero, one word a cycle, and holds busy high until the sweep ends; a clear
// request costs the same sweep. A fill runs five strips (body and four border
// strips); for each it loads the box, steps once per clip stack entry, and
// then reads, multiplies and writes each covered pixel in turn on the single
// frame store port. Push, pop, read and unknown requests go from dispatch
// straight to the response. Canvas size is to be written by the user through
// the csr_ port only while busy is low; the block does not enforce this.

module clipped_alpha_rect_fill
   import carf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_command,
   input  logic signed [15:0] req_rect_x,
   input  logic signed [15:0] req_rect_y,
   input  logic signed [15:0] req_rect_width,
   input  logic signed [15:0] req_rect_height,
   input  logic [31:0]        req_fill_color,
   input  logic [31:0]        req_border_color,
   input  logic [14:0]        req_border_width,
   output logic               rsp_valid,
   output logic [31:0]        rsp_pixel_rgba,
   output logic [1:0]         rsp_status,
   input  logic               csr_write,
   input  logic [0:0]         csr_index,
   input  logic [CSR_W-1:0]   csr_data
);

   // Canvas size registers, used clamped to 1..maximum.
   logic [CSR_W-1:0] canvas_w_ff, canvas_h_ff;
   logic [XW-1:0]    eff_w;
   logic [YW-1:0]    eff_h;

   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_w_ff <= CSR_W'(256);
         canvas_h_ff <= CSR_W'(256);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CANVAS_WIDTH:  canvas_w_ff <= csr_data;
            CSR_CANVAS_HEIGHT: canvas_h_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (canvas_w_ff == '0) eff_w = XW'(1);
      else if (32'(canvas_w_ff) > MAX_WIDTH) eff_w = XW'(MAX_WIDTH);
      else eff_w = XW'(canvas_w_ff);
      if (canvas_h_ff == '0) eff_h = YW'(1);
      else if (32'(canvas_h_ff) > MAX_HEIGHT) eff_h = YW'(MAX_HEIGHT);
      else eff_h = YW'(canvas_h_ff);
   end

   carf_cmd_type cmd;
   carf_sts_type sts;

   carf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   carf_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .eff_w            (eff_w),
      .eff_h            (eff_h),
      .req_command      (req_command),
      .req_rect_x       (req_rect_x),
      .req_rect_y       (req_rect_y),
      .req_rect_width   (req_rect_width),
      .req_rect_height  (req_rect_height),
      .req_fill_color   (req_fill_color),
      .req_border_color (req_border_color),
      .req_border_width (req_border_width),
      .rsp_pixel_rgba   (rsp_pixel_rgba),
      .rsp_status       (rsp_status)
   );

   // A response only appears while a request is in flight.
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response outside a request");

   // An accepted request keeps the engine busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("request accepted without going busy");

   // A response is a single-cycle strobe.
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response held more than one cycle");

   // Status is never the unused code, and pixel data only comes with a read.
   a_rsp_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STS_DONE || rsp_status == STS_FULL
                     || rsp_status == STS_OUTSIDE)
                    && (rsp_status == STS_DONE || rsp_pixel_rgba == '0))
      else $error("bad response status");

endmodule
